>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property p must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, p, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (p)) else $error(msg);
// Implication a |-> b at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
`endif

>>> sv/jdcal_pkg.sv
package jdcal_pkg;
   localparam int unsigned DayLimit      = 1000000000;
   localparam int unsigned LastJulianDay = 2299160;
   localparam int unsigned GregMarchZero = 1721120;
   localparam int unsigned Days400y      = 146097;
   localparam int unsigned Days100y      = 36524;
   localparam int unsigned Days4y        = 1461;
   localparam int unsigned StageCount    = 7;

   // Division by a constant as (x * Recip) >> Shift. The cycle estimates may
   // come out one low and get one correction step; the other two are exact
   // for every day of a 400-year era.
   localparam int unsigned Recip4y       = 2870;
   localparam int unsigned Shift4y       = 22;
   localparam int unsigned Recip400y     = 7349;
   localparam int unsigned Shift400y     = 30;
   localparam int unsigned Recip1460     = 183861;
   localparam int unsigned Shift1460     = 28;
   localparam int unsigned Recip365      = 183860;
   localparam int unsigned Shift365      = 26;

   typedef struct packed {
      logic [4:0]  day_of_month;
      logic [3:0]  month_of_year;
      logic [21:0] year_number;
      logic        era_bc;
      logic        out_of_range;
   } date_type;
endpackage

>>> sv/julian_day_to_calendar_date_top.sv
// Julian day number to calendar date converter.
// Input channel: req_valid/req_ready with req_day_number (days since
// 1 January 4713 BC). Result channel: rsp_valid/rsp_ready with day, month,
// year magnitude, BC flag and an out_of_range flag for inputs above 1e9.
// Days through 4 October 1582 follow the Julian calendar, later days the
// Gregorian calendar; every item gives exactly one result item.
// The datapath has seven register stages, the first loaded at the edge that
// accepts the item; one item can enter every cycle while the result side
// does not stall. The depth is set by the era division (a reciprocal
// estimate and a correction stage), the year of era (two reciprocal
// divisions in stages of their own), and the month lookup.
// A stall on the result side holds the whole pipeline; req_ready is low only
// while the last stage holds a result that rsp_ready does not take, so
// nothing is lost or repeated. Reset clears all valid bits; payload
// registers are not reset.
`include "assert_macros.svh"
module julian_day_to_calendar_date_top
   import jdcal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [29:0] req_day_number,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_day_of_month,
   output logic [3:0]  rsp_month_of_year,
   output logic [21:0] rsp_year_number,
   output logic        rsp_era_bc,
   output logic        rsp_out_of_range
);
   logic [StageCount-1:0] vld_ff;
   logic [StageCount-1:0] vld_in;
   logic                  adv;

   // The pipeline moves when the output slot is free or being emptied.
   assign adv       = !vld_ff[StageCount-1] || rsp_ready;
   assign req_ready = adv;

   always_comb begin
      vld_in = vld_ff;
      if (adv) begin
         vld_in = {vld_ff[StageCount-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: classify and compute the day offset for either calendar.
   logic        oor1_ff, jul1_ff;
   logic [29:0] z1_ff;
   logic [29:0] z1_in;
   logic        jul1_in;
   always_comb begin
      jul1_in = ({2'b0, req_day_number} <= 32'(LastJulianDay));
      z1_in   = jul1_in ? req_day_number : req_day_number - 30'(GregMarchZero);
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         oor1_ff <= ({2'b0, req_day_number} > 32'(DayLimit));
         jul1_ff <= jul1_in;
         z1_ff   <= z1_in;
      end
   end

   // Stage 2: estimate the cycle index (1461 or 146097 days) by reciprocal.
   // The estimate is never high and at most one low.
   logic        oor2_ff, jul2_ff;
   logic [29:0] z2_ff;
   logic [13:0] q2_ff;
   logic [43:0] pj;
   logic [42:0] pg;
   logic [13:0] q2_in;
   always_comb begin
      pj = 44'(z1_ff) * 44'(Recip4y);
      pg = 43'(z1_ff) * 43'(Recip400y);
      q2_in = jul1_ff ? 14'(pj >> Shift4y) : 14'(pg >> Shift400y);
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         oor2_ff <= oor1_ff;
         jul2_ff <= jul1_ff;
         z2_ff   <= z1_ff;
         q2_ff   <= q2_in;
      end
   end

   // Stage 3: remainder with one correction step.
   logic        oor3_ff, jul3_ff;
   logic [13:0] q3_ff;
   logic [17:0] doe3_ff;
   logic [31:0] prod3, rem3;
   logic [13:0] q3_in;
   logic [17:0] doe3_in;
   logic [17:0] cyc3;
   always_comb begin
      cyc3  = jul2_ff ? 18'(Days4y) : 18'(Days400y);
      prod3 = 32'(q2_ff) * 32'(cyc3);
      rem3  = 32'(z2_ff) - prod3;
      q3_in = q2_ff;
      if (rem3 >= 32'(cyc3)) begin
         rem3  = rem3 - 32'(cyc3);
         q3_in = q2_ff + 14'd1;
      end
      doe3_in = 18'(rem3);
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         oor3_ff <= oor2_ff;
         jul3_ff <= jul2_ff;
         q3_ff   <= q3_in;
         doe3_ff <= doe3_in;
      end
   end

   // Stage 4: Julian year of cycle by compares; Gregorian year numerator
   // doe - doe/1460 + doe/36524 - doe/146096.
   logic        oor4_ff, jul4_ff, leap4_ff;
   logic [13:0] q4_ff;
   logic [17:0] doe4_ff, t4_ff;
   logic [8:0]  yoej4_ff, doyj4_ff;
   logic [35:0] p1460;
   logic [6:0]  c1460;
   logic [2:0]  c36524;
   logic        c146096;
   logic [17:0] t4_in;
   logic [8:0]  yoej4_in, doyj4_in;
   logic        leap4_in;
   always_comb begin
      leap4_in = 1'b0;
      if (doe3_ff < 18'd366) begin
         yoej4_in = 9'd0;
         doyj4_in = 9'(doe3_ff);
         leap4_in = jul3_ff;
      end else if (doe3_ff < 18'd731) begin
         yoej4_in = 9'd1; doyj4_in = 9'(doe3_ff - 18'd366);
      end else if (doe3_ff < 18'd1096) begin
         yoej4_in = 9'd2; doyj4_in = 9'(doe3_ff - 18'd731);
      end else begin
         yoej4_in = 9'd3; doyj4_in = 9'(doe3_ff - 18'd1096);
      end
      p1460   = 36'(doe3_ff) * 36'(Recip1460);
      c1460   = 7'(p1460 >> Shift1460);
      c36524  = 3'(doe3_ff >= 18'(Days100y)) + 3'(doe3_ff >= 18'(2 * Days100y))
              + 3'(doe3_ff >= 18'(3 * Days100y)) + 3'(doe3_ff >= 18'(4 * Days100y));
      c146096 = (doe3_ff >= 18'(Days400y - 1));
      t4_in   = doe3_ff - 18'(c1460) + 18'(c36524) - 18'(c146096);
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         oor4_ff  <= oor3_ff;
         jul4_ff  <= jul3_ff;
         leap4_ff <= leap4_in;
         q4_ff    <= q3_ff;
         doe4_ff  <= doe3_ff;
         t4_ff    <= t4_in;
         yoej4_ff <= yoej4_in;
         doyj4_ff <= doyj4_in;
      end
   end

   // Stage 5: Gregorian year of era, the numerator divided by 365; the Julian year of cycle passes through.
   logic        oor5_ff, jul5_ff, leap5_ff;
   logic [13:0] q5_ff;
   logic [17:0] doe5_ff;
   logic [8:0]  yoe5_ff, doyj5_ff;
   logic [35:0] p365;
   logic [8:0]  yoe5_in;
   always_comb begin
      p365    = 36'(t4_ff) * 36'(Recip365);
      yoe5_in = jul4_ff ? yoej4_ff : 9'(p365 >> Shift365);
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         oor5_ff  <= oor4_ff;
         jul5_ff  <= jul4_ff;
         leap5_ff <= leap4_ff;
         q5_ff    <= q4_ff;
         doe5_ff  <= doe4_ff;
         yoe5_ff  <= yoe5_in;
         doyj5_ff <= doyj4_ff;
      end
   end

   // Stage 6: day of (shifted) year and year index.
   logic        oor6_ff, jul6_ff, leap6_ff;
   logic [8:0]  doy6_ff;
   logic [21:0] yidx6_ff;
   logic [1:0]  c100;
   logic [17:0] base6;
   logic [8:0]  doy6_in;
   logic [21:0] yidx6_in;
   always_comb begin
      c100  = 2'(yoe5_ff >= 9'd100) + 2'(yoe5_ff >= 9'd200) + 2'(yoe5_ff >= 9'd300);
      base6 = 18'(yoe5_ff) * 18'd365 + 18'(yoe5_ff >> 2) - 18'(c100);
      if (jul5_ff) begin
         doy6_in  = doyj5_ff;
         yidx6_in = 22'(q5_ff) * 22'd4 + 22'(yoe5_ff);
      end else begin
         doy6_in  = 9'(doe5_ff - base6);
         yidx6_in = 22'(q5_ff) * 22'd400 + 22'(yoe5_ff);
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         oor6_ff  <= oor5_ff;
         jul6_ff  <= jul5_ff;
         leap6_ff <= leap5_ff;
         doy6_ff  <= doy6_in;
         yidx6_ff <= yidx6_in;
      end
   end

   // First day of each month within the year, counted from January for the
   // Julian path and from March for the Gregorian path.
   function automatic logic [8:0] month_start(input logic [3:0] idx,
                                              input logic jan_based, input logic leap);
      logic [8:0] s;
      s = 9'd0;
      if (jan_based) begin
         case (idx)
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd59;
            4'd3:    s = 9'd90;
            4'd4:    s = 9'd120;
            4'd5:    s = 9'd151;
            4'd6:    s = 9'd181;
            4'd7:    s = 9'd212;
            4'd8:    s = 9'd243;
            4'd9:    s = 9'd273;
            4'd10:   s = 9'd304;
            4'd11:   s = 9'd334;
            default: s = 9'd0;
         endcase
         if (leap && idx >= 4'd2) begin
            s = s + 9'd1;
         end
      end else begin
         case (idx)
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
         endcase
      end
      return s;
   endfunction

   // Stage 7: month and day, year and era; this stage is the output register.
   date_type res_ff, res_in;
   logic [3:0]  mi7, mo7;
   logic [8:0]  st7;
   always_comb begin
      res_in = '0;
      mi7    = 4'd0;
      mo7    = 4'd0;
      st7    = '0;
      // The last month whose first day is not after the day of year.
      for (int i = 1; i < 12; i++) begin
         if (doy6_ff >= month_start(4'(i), jul6_ff, leap6_ff)) begin
            mi7 = 4'(i);
            st7 = month_start(4'(i), jul6_ff, leap6_ff);
         end
      end
      res_in.day_of_month = 5'(doy6_ff - st7 + 9'd1);
      if (jul6_ff) begin
         res_in.month_of_year = mi7 + 4'd1;
         if (yidx6_ff <= 22'd4712) begin
            res_in.year_number = 22'd4713 - yidx6_ff;
            res_in.era_bc      = 1'b1;
         end else begin
            res_in.year_number = yidx6_ff - 22'd4712;
         end
      end else begin
         // January and February belong to the next year.
         mo7 = (mi7 < 4'd10) ? mi7 + 4'd3 : mi7 - 4'd9;
         res_in.month_of_year = mo7;
         res_in.year_number   = yidx6_ff + ((mo7 <= 4'd2) ? 22'd1 : 22'd0);
      end
      if (oor6_ff) begin
         res_in = '0;
         res_in.out_of_range = 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid         = vld_ff[StageCount-1];
   assign rsp_day_of_month  = res_ff.day_of_month;
   assign rsp_month_of_year = res_ff.month_of_year;
   assign rsp_year_number   = res_ff.year_number;
   assign rsp_era_bc        = res_ff.era_bc;
   assign rsp_out_of_range  = res_ff.out_of_range;

   // A result that is stalled holds its valid bit.
   `ASSERT_IMPL(a_hold, clock, reset, rsp_valid && !rsp_ready, ##1 rsp_valid, "result dropped")
   // Out of range results carry an all-zero date.
   `ASSERT_IMPL(a_oor, clock, reset, rsp_valid && rsp_out_of_range,
      rsp_month_of_year == 4'd0, "oor date")
   // Valid results carry a month between 1 and 12 when in range.
   `ASSERT_IMPL(a_mon, clock, reset, rsp_valid && !rsp_out_of_range,
      rsp_month_of_year >= 4'd1 && rsp_month_of_year <= 4'd12, "bad month")
endmodule

>>> sim/tb_top.sv
module tb_top
   import jdcal_pkg::*;
();

   // Directed rows carry a typed-in date only where it is known at a glance.
   typedef struct {
      logic [29:0] day_number;
      logic        has_date;
      date_type    date;
   } day_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [29:0] req_day_number = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [4:0]  rsp_day_of_month;
   logic [3:0]  rsp_month_of_year;
   logic [21:0] rsp_year_number;
   logic        rsp_era_bc;
   logic        rsp_out_of_range;

   date_type    pending_dates[$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   bit          sender_idle_ok = 1'b1;
   bit          receiver_idle_ok = 1'b1;
   bit          receiver_hold = 1'b0;
   bit          hold_request = 1'b0;

   localparam int unsigned CycleLimit = 200000;

   julian_day_to_calendar_date_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_day_number(req_day_number),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_day_of_month(rsp_day_of_month), .rsp_month_of_year(rsp_month_of_year),
      .rsp_year_number(rsp_year_number), .rsp_era_bc(rsp_era_bc),
      .rsp_out_of_range(rsp_out_of_range)
   );

   always #5 clock = ~clock;

   // Compute the calendar date of a day count.
   function automatic date_type calendar_date(input logic [29:0] day_number);
      date_type    res;
      int unsigned month_days[12] = '{31,28,31,30,31,30,31,31,30,31,30,31};
      longint unsigned r, cyc, rem, yo, idx, len, z, era, doe, yoe, doy, mp, yr, mo;
      bit          leap;
      int unsigned i;
      res = '0;
      r = 64'(day_number);
      if (r > DayLimit) begin
         res.out_of_range = 1'b1;
      end else if (r <= LastJulianDay) begin
         // Julian calendar; the first year of each four-year cycle is leap.
         cyc = r / Days4y;
         rem = r % Days4y;
         if (rem < 366) begin
            yo = 0;
            leap = 1'b1;
         end else begin
            rem = rem - 366;
            yo = 1 + rem / 365;
            rem = rem % 365;
            leap = 1'b0;
         end
         idx = cyc * 4 + yo;
         for (i = 0; i < 11; i++) begin
            len = 64'(month_days[i]);
            if (i == 1 && leap) len++;
            if (rem < len) break;
            rem -= len;
         end
         res.day_of_month = 5'(rem + 1);
         res.month_of_year = 4'(i + 1);
         if (idx <= 4712) begin
            res.year_number = 22'(4713 - idx);
            res.era_bc = 1'b1;
         end else begin
            res.year_number = 22'(idx - 4712);
         end
      end else begin
         // Gregorian calendar in 400-year eras starting 1 March of year 0.
         z = r - GregMarchZero;
         era = z / Days400y;
         doe = z - era * Days400y;
         yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
         doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
         mp = (5 * doy + 2) / 153;
         yr = yoe + era * 400;
         res.day_of_month = 5'(doy - (153 * mp + 2) / 5 + 1);
         mo = (mp < 10) ? mp + 3 : mp - 9;
         if (mo <= 2) yr++;
         res.month_of_year = 4'(mo);
         res.year_number = 22'(yr);
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   // Send one item, with random idle cycles before it when allowed.
   task automatic send_day(input logic [29:0] day_number, input bit has_date,
                           input date_type date);
      while (sender_idle_ok && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      pending_dates.push_back(has_date ? date : calendar_date(day_number));
      req_valid <= 1'b1;
      req_day_number <= day_number;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering items and wait until every expected result has come.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_dates.size() != 0) @(posedge clock);
   endtask

   // Receiver readiness: random idling, plus a long hold when requested.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !receiver_hold && !(receiver_idle_ok && $urandom_range(99) < 9);
      end
   end

   // Long hold-off, counted in cycles here.
   initial begin
      wait (hold_request);
      @(posedge clock);
      receiver_hold = 1'b1;
      repeat (60) @(posedge clock);
      receiver_hold = 1'b0;
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      date_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_dates.size() == 0) begin
            report_mismatch("unexpected item, queue depth", 0, 1);
         end else begin
            want = pending_dates.pop_front();
            if (rsp_day_of_month !== want.day_of_month)
               report_mismatch("day_of_month", rsp_day_of_month, want.day_of_month);
            if (rsp_month_of_year !== want.month_of_year)
               report_mismatch("month_of_year", rsp_month_of_year, want.month_of_year);
            if (rsp_year_number !== want.year_number)
               report_mismatch("year_number", rsp_year_number, want.year_number);
            if (rsp_era_bc !== want.era_bc)
               report_mismatch("era_bc", rsp_era_bc, want.era_bc);
            if (rsp_out_of_range !== want.out_of_range)
               report_mismatch("out_of_range", rsp_out_of_range, want.out_of_range);
         end
      end
   end

   // Timeout.
   always @(posedge clock) begin
      if (cycle_count >= CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      day_row_type rows[$];
      day_row_type row;
      int unsigned n;
      int unsigned pick;
      logic [29:0] day_number;

      // Day zero, calendar switchover, extremes, above-range values.
      rows.push_back('{30'd0,          1'b1, '{5'd1, 4'd1, 22'd4713, 1'b1, 1'b0}});
      rows.push_back('{30'd365,        1'b1, '{5'd31, 4'd12, 22'd4713, 1'b1, 1'b0}});
      rows.push_back('{30'd366,        1'b1, '{5'd1, 4'd1, 22'd4712, 1'b1, 1'b0}});
      rows.push_back('{30'd59,         1'b1, '{5'd29, 4'd2, 22'd4713, 1'b1, 1'b0}});
      rows.push_back('{30'd2299160,    1'b1, '{5'd4, 4'd10, 22'd1582, 1'b0, 1'b0}});
      rows.push_back('{30'd2299161,    1'b1, '{5'd15, 4'd10, 22'd1582, 1'b0, 1'b0}});
      rows.push_back('{30'd1000000001, 1'b1, '{5'd0, 4'd0, 22'd0, 1'b0, 1'b1}});
      rows.push_back('{30'h3FFFFFFF,   1'b1, '{5'd0, 4'd0, 22'd0, 1'b0, 1'b1}});
      rows.push_back('{30'h2AAAAAAA,   1'b0, '0});
      rows.push_back('{30'd1000000000, 1'b0, '0});
      rows.push_back('{30'd1721057,    1'b0, '0});
      rows.push_back('{30'd1721058,    1'b0, '0});
      rows.push_back('{30'd1721423,    1'b0, '0});
      rows.push_back('{30'd1721424,    1'b0, '0});
      rows.push_back('{30'd2451544,    1'b0, '0});
      rows.push_back('{30'd2451604,    1'b0, '0});
      rows.push_back('{30'd2415079,    1'b0, '0});
      rows.push_back('{30'd2299239,    1'b0, '0});
      rows.push_back('{30'd2305447,    1'b0, '0});
      rows.push_back('{30'h15555555,   1'b0, '0});

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         row = rows[i];
         send_day(row.day_number, row.has_date, row.date);
      end

      // Random part: mostly historical days, some full range and above range.
      for (n = 0; n < 930; n++) begin
         sender_idle_ok = !(n >= 300 && n < 450);
         receiver_idle_ok = !(n >= 300 && n < 450);
         if (n == 500) hold_request = 1'b1;
         if (n == 700) begin
            // Drain fully before continuing.
            drain_results();
         end
         pick = $urandom_range(99);
         if (pick < 50) day_number = 30'($urandom_range(2299160));
         else if (pick < 70) day_number = 30'(2299160 + $urandom_range(500000));
         else if (pick < 90) day_number = 30'($urandom_range(1000000000));
         else if (pick < 95) day_number = 30'($urandom_range(10) + 999999995);
         else day_number = 30'($urandom);
         send_day(day_number, 1'b0, '0);
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
